// ===== hw/rtl/r2f_pkg.sv =====
// ----------------------------------------------------------------------------
// r2f_pkg
// shared types, register codes and twiddle table generation for the
// radix-2 decimation-in-frequency fft
// ----------------------------------------------------------------------------
package r2f_pkg;

  localparam int MAX_SIZE_LOG2_DEF = 12;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int TWIDDLE_BITS_DEF  = 16;
  localparam int DATA_BITS_DEF     = 30;
  localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic {
    REG_SIZE_LOG2 = 1'b0,
    REG_INVERSE   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD_A,
    ST_RD_B,
    ST_SUM,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_FETCH
  } state_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_P0,
    MS_P1,
    MS_P2,
    MS_P3,
    MS_P4
  } mul_step_t;

  typedef struct packed {
    logic      load_a;
    logic      load_b;
    mul_step_t step;
    logic      swap;
    logic      scale;
  } bf_ctrl_t;

  // shift and subtract quotient, only evaluated while the twiddle table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos or sin magnitude over one quadrant, q30 in and out
  function automatic logic [63:0] taylor_q30(input logic [63:0] x, input logic want_sin);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] d;
    longint      acc;
    x2   = (x * x) >> 30;
    term = want_sin ? x : ONE_Q30;
    acc  = longint'(term);
    for (int n = 1; n <= 14; n++) begin
      d = want_sin ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = udiv64((term * x2) >> 30, d);
      if ((n & 1) == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    return 64'(acc);
  endfunction

  function automatic logic [23:0] to_twiddle(input logic [63:0] q30, input logic neg,
                                             input int tw_bits);
    logic [63:0] q;
    logic [63:0] top;
    int          r;
    r   = 31 - tw_bits;
    q   = (q30 + (64'd1 << (r - 1))) >> r;
    top = (64'd1 << (tw_bits - 1)) - 64'd1;
    if (q > top) q = top;
    return neg ? 24'(-q) : 24'(q);
  endfunction

  // {imag, real}, each 24 bits, sign in the low tw_bits
  function automatic logic [47:0] twiddle_entry(input int t, input int max_log2,
                                                input int tw_bits);
    logic [63:0] x;
    logic [23:0] wr;
    logic [23:0] wi;
    int          max_n;
    max_n = 1 << max_log2;
    if (4 * t < max_n) begin
      x  = (PI_Q30 * 64'(t)) >> (max_log2 - 1);
      wr = to_twiddle(taylor_q30(x, 1'b0), 1'b0, tw_bits);
      wi = to_twiddle(taylor_q30(x, 1'b1), 1'b1, tw_bits);
    end else begin
      x  = (PI_Q30 * 64'(t - (max_n >> 2))) >> (max_log2 - 1);
      wr = to_twiddle(taylor_q30(x, 1'b1), 1'b1, tw_bits);
      wi = to_twiddle(taylor_q30(x, 1'b0), 1'b1, tw_bits);
    end
    return {wi, wr};
  endfunction

endpackage

// ===== hw/rtl/radix2_dif_fft.sv =====
// ----------------------------------------------------------------------------
// radix2_dif_fft
// in-place radix-2 decimation-in-frequency fft over one work memory
// ----------------------------------------------------------------------------
// A load writes the work memory directly; a fetch holds until the output is
// free. The load marked last starts the transform: first the entries not
// loaded are zeroed, then N/2*log2(N) butterflies run in turn through the
// states RD_A to M5, serialized by the single read and single write port of
// the work memory and the one multiplier that forms the four twiddle products
// in turn. Input is not accepted while the transform runs. Samples go in as
// 16-bit values, bins come out in natural order as 30-bit saturated words; a
// fetch without a finished transform returns no_result with zero data.
module radix2_dif_fft #(
  parameter int MAX_SIZE_LOG2 = r2f_pkg::MAX_SIZE_LOG2_DEF,
  parameter int SAMPLE_BITS   = r2f_pkg::SAMPLE_BITS_DEF,
  parameter int TWIDDLE_BITS  = r2f_pkg::TWIDDLE_BITS_DEF,
  parameter int DATA_BITS     = r2f_pkg::DATA_BITS_DEF,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * DATA_BITS + MAX_SIZE_LOG2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // sample_real, sample_imag
  input  logic             s_tuser,   // operation
  input  logic             s_tlast,   // last_sample
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // result_real, result_imag, bin_index
  output logic             m_tuser,   // no_result
  output logic             m_tlast,   // last_bin
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int D      = DATA_BITS;
  localparam int AW     = MAX_SIZE_LOG2;
  localparam int MAX_N  = 1 << MAX_SIZE_LOG2;
  localparam int LG_W   = $clog2(MAX_SIZE_LOG2 + 1);
  localparam int TW_AW  = (MAX_SIZE_LOG2 > 1) ? MAX_SIZE_LOG2 - 1 : 1;

  r2f_pkg::state_t   state, state_next;
  r2f_pkg::bf_ctrl_t ctrl;

  logic [3:0]        size_log2;
  logic              inverse_mode;
  logic [AW:0]       load_count, lc_inc;
  logic [AW-1:0]     fetch_index, f_idx;
  logic              transform_done, f_none;
  logic [LG_W-1:0]   eff_lg, run_lg, stage;
  logic              run_inv;
  logic [AW-1:0]     cnt, cnt_last, mask, addr_a, addr_b, rev_full, rev_addr;
  logic [AW:0]       n_cur, n_run;
  logic [TW_AW-1:0]  tw_addr;

  logic              ram_we, ram_re, rom_re;
  logic [AW-1:0]     waddr, raddr;
  logic [2*D-1:0]    wdata, rdata, sum_word, diff_word;
  logic signed [TWIDDLE_BITS-1:0] tw_real, tw_imag;

  logic signed [SAMPLE_BITS-1:0] sample_real, sample_imag;
  logic              in_acc, out_free, cfg_wr;
  r2f_pkg::op_t      op;

  logic signed [D-1:0] result_real, result_imag;
  logic [AW-1:0]       bin_index;
  logic                last_bin, no_result;

  assign sample_real = s_tdata[SAMPLE_BITS-1:0];
  assign sample_imag = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign op          = r2f_pkg::op_t'(s_tuser);
  assign s_tready    = (state == r2f_pkg::ST_IDLE);
  assign in_acc      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign cfg_wr      = psel && penable && pwrite;
  assign pready      = 1'b1;

  always_comb begin
    unique case (r2f_pkg::cfg_reg_t'(paddr[2]))
      r2f_pkg::REG_SIZE_LOG2: prdata = {28'd0, size_log2};
      r2f_pkg::REG_INVERSE:   prdata = {31'd0, inverse_mode};
      default:                prdata = '0;
    endcase
  end

  // length in force, out-of-range sizes clamp
  always_comb begin
    if (size_log2 == 4'd0) eff_lg = LG_W'(1);
    else if (int'(size_log2) > MAX_SIZE_LOG2) eff_lg = LG_W'(MAX_SIZE_LOG2);
    else eff_lg = LG_W'(size_log2);
  end

  assign n_cur    = (AW+1)'(1) << eff_lg;
  assign n_run    = (AW+1)'(1) << run_lg;
  assign lc_inc   = (load_count < n_cur) ? load_count + (AW+1)'(1) : load_count;
  assign cnt_last = AW'((n_run >> 1) - (AW+1)'(1));

  // butterfly addressing for the current stage
  assign mask    = (AW'(1) << (stage - LG_W'(1))) - AW'(1);
  assign addr_a  = ((cnt & ~mask) << 1) | (cnt & mask);
  assign addr_b  = addr_a | (mask + AW'(1));
  assign tw_addr = TW_AW'((cnt & mask) << (LG_W'(MAX_SIZE_LOG2) - stage));

  always_comb begin
    for (int i = 0; i < AW; i++) rev_full[i] = fetch_index[AW-1-i];
  end
  assign rev_addr = rev_full >> (LG_W'(AW) - run_lg);

  always_comb begin
    state_next   = state;
    ram_we       = 1'b0;
    waddr        = '0;
    wdata        = '0;
    ram_re       = 1'b0;
    raddr        = '0;
    rom_re       = 1'b0;
    ctrl.load_a  = 1'b0;
    ctrl.load_b  = 1'b0;
    ctrl.step    = r2f_pkg::MS_NONE;
    ctrl.swap    = run_inv && (stage == run_lg);
    ctrl.scale   = run_inv && (stage == LG_W'(1));
    unique case (state)
      r2f_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (op == r2f_pkg::OP_LOAD) begin
            if (load_count < n_cur) begin
              ram_we = 1'b1;
              waddr  = load_count[AW-1:0];
              wdata  = {D'(sample_imag), D'(sample_real)};
            end
            if (s_tlast) begin
              state_next = (lc_inc < n_cur) ? r2f_pkg::ST_CLEAR : r2f_pkg::ST_RD_A;
            end
          end else begin
            ram_re     = transform_done;
            raddr      = rev_addr;
            state_next = r2f_pkg::ST_FETCH;
          end
        end
      end
      r2f_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        waddr  = load_count[AW-1:0];
        if (load_count + (AW+1)'(1) == n_run) state_next = r2f_pkg::ST_RD_A;
      end
      r2f_pkg::ST_RD_A: begin
        ram_re     = 1'b1;
        raddr      = addr_a;
        rom_re     = 1'b1;
        state_next = r2f_pkg::ST_RD_B;
      end
      r2f_pkg::ST_RD_B: begin
        ram_re      = 1'b1;
        raddr       = addr_b;
        ctrl.load_a = 1'b1;
        state_next  = r2f_pkg::ST_SUM;
      end
      r2f_pkg::ST_SUM: begin
        ctrl.load_b = 1'b1;
        state_next  = r2f_pkg::ST_M0;
      end
      r2f_pkg::ST_M0: begin
        ram_we     = 1'b1;
        waddr      = addr_a;
        wdata      = sum_word;
        ctrl.step  = r2f_pkg::MS_P0;
        state_next = r2f_pkg::ST_M1;
      end
      r2f_pkg::ST_M1: begin
        ctrl.step  = r2f_pkg::MS_P1;
        state_next = r2f_pkg::ST_M2;
      end
      r2f_pkg::ST_M2: begin
        ctrl.step  = r2f_pkg::MS_P2;
        state_next = r2f_pkg::ST_M3;
      end
      r2f_pkg::ST_M3: begin
        ctrl.step  = r2f_pkg::MS_P3;
        state_next = r2f_pkg::ST_M4;
      end
      r2f_pkg::ST_M4: begin
        ctrl.step  = r2f_pkg::MS_P4;
        state_next = r2f_pkg::ST_M5;
      end
      r2f_pkg::ST_M5: begin
        ram_we = 1'b1;
        waddr  = addr_b;
        wdata  = diff_word;
        if (cnt == cnt_last && stage == LG_W'(1)) state_next = r2f_pkg::ST_IDLE;
        else state_next = r2f_pkg::ST_RD_A;
      end
      r2f_pkg::ST_FETCH: begin
        if (out_free) state_next = r2f_pkg::ST_IDLE;
      end
      default: state_next = r2f_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= r2f_pkg::ST_IDLE;
      size_log2      <= r2f_pkg::SIZE_LOG2_RESET;
      inverse_mode   <= 1'b0;
      load_count     <= '0;
      fetch_index    <= '0;
      transform_done <= 1'b0;
      run_lg         <= LG_W'(1);
      run_inv        <= 1'b0;
      stage          <= LG_W'(1);
      cnt            <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        unique case (r2f_pkg::cfg_reg_t'(paddr[2]))
          r2f_pkg::REG_SIZE_LOG2: size_log2    <= pwdata[3:0];
          r2f_pkg::REG_INVERSE:   inverse_mode <= pwdata[0];
          default: ;
        endcase
      end
      if (state == r2f_pkg::ST_FETCH && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        r2f_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (op == r2f_pkg::OP_LOAD) begin
              transform_done <= 1'b0;
              fetch_index    <= '0;
              if (s_tlast) begin
                run_lg     <= eff_lg;
                run_inv    <= inverse_mode;
                stage      <= eff_lg;
                cnt        <= '0;
                load_count <= (lc_inc < n_cur) ? lc_inc : '0;
              end else begin
                load_count <= lc_inc;
              end
            end else if (transform_done) begin
              fetch_index <= (fetch_index + AW'(1)) & AW'(n_run - (AW+1)'(1));
            end
          end
        end
        r2f_pkg::ST_CLEAR: begin
          if (load_count + (AW+1)'(1) == n_run) load_count <= '0;
          else load_count <= load_count + (AW+1)'(1);
        end
        r2f_pkg::ST_M5: begin
          if (cnt == cnt_last) begin
            cnt <= '0;
            if (stage == LG_W'(1)) begin
              transform_done <= 1'b1;
              fetch_index    <= '0;
            end else begin
              stage <= stage - LG_W'(1);
            end
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // fetch bookkeeping and result register
  always_ff @(posedge clk) begin
    if (state == r2f_pkg::ST_IDLE && in_acc && op == r2f_pkg::OP_FETCH) begin
      f_idx  <= fetch_index;
      f_none <= !transform_done;
    end
    if (state == r2f_pkg::ST_FETCH && out_free) begin
      if (f_none) begin
        result_real <= '0;
        result_imag <= '0;
        bin_index   <= '0;
        last_bin    <= 1'b0;
        no_result   <= 1'b1;
      end else begin
        result_real <= run_inv ? rdata[2*D-1:D] : rdata[D-1:0];
        result_imag <= run_inv ? rdata[D-1:0]   : rdata[2*D-1:D];
        bin_index   <= f_idx;
        last_bin    <= (f_idx == AW'(n_run - (AW+1)'(1)));
        no_result   <= 1'b0;
      end
    end
  end

  assign m_tdata = OUT_W'({bin_index, result_imag, result_real});
  assign m_tuser = no_result;
  assign m_tlast = last_bin;

  r2f_ram #(
    .WIDTH(2 * D),
    .DEPTH(MAX_N)
  ) u_work (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ram_re),
    .raddr(raddr),
    .rdata(rdata)
  );

  r2f_twiddle_rom #(
    .MAX_SIZE_LOG2(MAX_SIZE_LOG2),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_twiddle (
    .clk    (clk),
    .re     (rom_re),
    .addr   (tw_addr),
    .tw_real(tw_real),
    .tw_imag(tw_imag)
  );

  r2f_butterfly #(
    .DATA_BITS   (D),
    .TWIDDLE_BITS(TWIDDLE_BITS),
    .LG_W        (LG_W)
  ) u_bfly (
    .clk      (clk),
    .ctrl     (ctrl),
    .shift_amt(run_lg),
    .rd_word  (rdata),
    .tw_real  (tw_real),
    .tw_imag  (tw_imag),
    .sum_word (sum_word),
    .diff_word(diff_word)
  );

  a_load_count_range: assert property (@(posedge clk) disable iff (rst)
    load_count <= (AW+1)'(MAX_N))
    else $error("load count beyond work memory depth");

  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    (state == r2f_pkg::ST_RD_A) |-> (stage != '0 && stage <= run_lg))
    else $error("butterfly stage out of range");

  a_no_result_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
    else $error("no_result transaction carries data");

  a_done_fetch_start: assert property (@(posedge clk) disable iff (rst)
    $rose(transform_done) |-> (fetch_index == '0 && state == r2f_pkg::ST_IDLE))
    else $error("transform finished with stale fetch index");

endmodule

// ===== hw/rtl/r2f_ram.sv =====
// ----------------------------------------------------------------------------
// r2f_ram
// generic single-write single-read memory with registered read data
// ----------------------------------------------------------------------------
module r2f_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/r2f_twiddle_rom.sv =====
// ----------------------------------------------------------------------------
// r2f_twiddle_rom
// q1.(n-1) twiddle table over half a circle, built at elaboration, registered read
// ----------------------------------------------------------------------------
module r2f_twiddle_rom #(
  parameter int MAX_SIZE_LOG2 = r2f_pkg::MAX_SIZE_LOG2_DEF,
  parameter int TWIDDLE_BITS  = r2f_pkg::TWIDDLE_BITS_DEF,
  localparam int TW_N  = 1 << ((MAX_SIZE_LOG2 > 1) ? MAX_SIZE_LOG2 - 1 : 0),
  localparam int TW_AW = (MAX_SIZE_LOG2 > 1) ? MAX_SIZE_LOG2 - 1 : 1
) (
  input  logic                           clk,
  input  logic                           re,
  input  logic [TW_AW-1:0]               addr,
  output logic signed [TWIDDLE_BITS-1:0] tw_real,
  output logic signed [TWIDDLE_BITS-1:0] tw_imag
);

  logic [2*TWIDDLE_BITS-1:0] tab [TW_N];
  logic [2*TWIDDLE_BITS-1:0] rd;

  for (genvar g = 0; g < TW_N; g++) begin : g_entry
    localparam logic [47:0] ENTRY = r2f_pkg::twiddle_entry(g, MAX_SIZE_LOG2, TWIDDLE_BITS);
    assign tab[g] = {ENTRY[24+TWIDDLE_BITS-1:24], ENTRY[TWIDDLE_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (re) rd <= tab[addr];
  end

  assign tw_real = rd[TWIDDLE_BITS-1:0];
  assign tw_imag = rd[2*TWIDDLE_BITS-1:TWIDDLE_BITS];

endmodule

// ===== hw/rtl/r2f_butterfly.sv =====
// ----------------------------------------------------------------------------
// r2f_butterfly
// butterfly datapath: saturating sum and difference, one shared multiplier
// stepped four times for the twiddle product, rounding and inverse-mode 1/n scaling
// ----------------------------------------------------------------------------
module r2f_butterfly #(
  parameter int DATA_BITS    = r2f_pkg::DATA_BITS_DEF,
  parameter int TWIDDLE_BITS = r2f_pkg::TWIDDLE_BITS_DEF,
  parameter int LG_W         = 4
) (
  input  logic                           clk,
  input  r2f_pkg::bf_ctrl_t              ctrl,
  input  logic [LG_W-1:0]                shift_amt,
  input  logic [2*DATA_BITS-1:0]         rd_word,
  input  logic signed [TWIDDLE_BITS-1:0] tw_real,
  input  logic signed [TWIDDLE_BITS-1:0] tw_imag,
  output logic [2*DATA_BITS-1:0]         sum_word,
  output logic [2*DATA_BITS-1:0]         diff_word
);

  localparam int D     = DATA_BITS;
  localparam int T     = TWIDDLE_BITS;
  localparam int PW    = D + T;
  localparam int ACC_W = D + T + 1;
  localparam logic signed [D-1:0] DMAX = {1'b0, {(D-1){1'b1}}};
  localparam logic signed [D-1:0] DMIN = {1'b1, {(D-1){1'b0}}};

  logic signed [D-1:0]     in_re, in_im;
  logic signed [D-1:0]     a_re, a_im;
  logic signed [D-1:0]     sum_re, sum_im, dr, di, res_re;
  logic signed [D-1:0]     mul_a;
  logic signed [T-1:0]     mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [D-1:0]     acc_rnd;

  function automatic logic signed [D-1:0] sat1(input logic signed [D:0] v);
    if (v[D] != v[D-1]) return v[D] ? DMIN : DMAX;
    return v[D-1:0];
  endfunction

  function automatic logic signed [D-1:0] rnd(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    logic signed [D+1:0]     s;
    r = (v + (ACC_W'(1) <<< (T - 2))) >>> (T - 1);
    s = r[D+1:0];
    if (s > (D+2)'(DMAX)) return DMAX;
    if (s < (D+2)'(DMIN)) return DMIN;
    return s[D-1:0];
  endfunction

  function automatic logic signed [D-1:0] scl(input logic signed [D-1:0] v, input logic en,
                                               input logic [LG_W-1:0] sh);
    return en ? (v >>> sh) : v;
  endfunction

  // inverse mode swaps real and imaginary on the first stage read
  assign in_re = ctrl.swap ? rd_word[2*D-1:D] : rd_word[D-1:0];
  assign in_im = ctrl.swap ? rd_word[D-1:0]   : rd_word[2*D-1:D];

  always_comb begin
    unique case (ctrl.step)
      r2f_pkg::MS_P0: begin mul_a = dr; mul_b = tw_real; end
      r2f_pkg::MS_P1: begin mul_a = di; mul_b = tw_imag; end
      r2f_pkg::MS_P2: begin mul_a = dr; mul_b = tw_imag; end
      r2f_pkg::MS_P3: begin mul_a = di; mul_b = tw_real; end
      default:        begin mul_a = dr; mul_b = tw_real; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_a) begin
      a_re <= in_re;
      a_im <= in_im;
    end
    if (ctrl.load_b) begin
      sum_re <= sat1((D+1)'(a_re) + (D+1)'(in_re));
      sum_im <= sat1((D+1)'(a_im) + (D+1)'(in_im));
      dr     <= sat1((D+1)'(a_re) - (D+1)'(in_re));
      di     <= sat1((D+1)'(a_im) - (D+1)'(in_im));
    end
    prod <= PW'(mul_a) * PW'(mul_b);
    unique case (ctrl.step)
      r2f_pkg::MS_P1: acc <= ACC_W'(prod);
      r2f_pkg::MS_P2: acc <= acc - ACC_W'(prod);
      r2f_pkg::MS_P3: begin
        res_re <= acc_rnd;
        acc    <= ACC_W'(prod);
      end
      r2f_pkg::MS_P4: acc <= acc + ACC_W'(prod);
      default: ;
    endcase
  end

  assign acc_rnd   = rnd(acc);
  assign sum_word  = {scl(sum_im, ctrl.scale, shift_amt), scl(sum_re, ctrl.scale, shift_amt)};
  assign diff_word = {scl(acc_rnd, ctrl.scale, shift_amt), scl(res_re, ctrl.scale, shift_amt)};

endmodule
